### rtl/bdpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdpq_pkg
// Shared types and constants for the button debounce and press queue block.
// ----------------------------------------------------------------------------
package bdpq_pkg;

	localparam int NUM_BUTTONS  = 6;
	localparam int HISTORY_BITS = 8;
	localparam int ACTION_W     = 2;
	localparam int AGREE_W      = 4;
	localparam int CMD_W        = $clog2(NUM_BUTTONS + 1);

	localparam logic [AGREE_W-1:0] AGREE_RESET = AGREE_W'(4);

	typedef enum logic [ACTION_W-1:0] {
		ACT_SAMPLE   = 2'd0,
		ACT_EVALUATE = 2'd1,
		ACT_FETCH    = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	typedef logic [NUM_BUTTONS-1:0]  btn_vec_t;
	typedef logic [HISTORY_BITS-1:0] hist_t;
	typedef logic [CMD_W-1:0]        cmd_t;

endpackage
`default_nettype wire

### rtl/bdpq_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdpq channel interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface bdpq_item_if import bdpq_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	btn_vec_t            raw_buttons;

	modport source (output valid, output action, output raw_buttons, input ready);
	modport sink   (input valid, input action, input raw_buttons, output ready);
endinterface

interface bdpq_result_if import bdpq_pkg::*; ;
	logic     valid;
	logic     ready;
	cmd_t     command;
	btn_vec_t stable_levels;
	btn_vec_t pending_presses;

	modport source (output valid, output command, output stable_levels,
		output pending_presses, input ready);
	modport sink   (input valid, input command, input stable_levels,
		input pending_presses, output ready);
endinterface

interface bdpq_cfg_if import bdpq_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [AGREE_W-1:0] agree_count;

	modport source (output valid, output agree_count, input ready);
	modport sink   (input valid, input agree_count, output ready);
endinterface
`default_nettype wire

### rtl/button_debounce_press_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_press_queue
// Shift-register debouncer for active-low buttons with a queue of presses.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  item     in   action, raw_buttons
//  result   out  command, stable_levels, pending_presses
//  cfg      in   agree_count (always ready)
//
//  One request per cycle sustained while the result side takes results; each
//  result is presented from the result register, which loads after its
//  request is taken into the input register.
//  History, level and press updates happen in the single step from input to
//  result register. A stalled result holds the result register; an empty input
//  register still takes one more request, then ready drops until the result moves.
//  Reset sets agree_count to 4, levels high, history and presses clear.
// ----------------------------------------------------------------------------
module button_debounce_press_queue import bdpq_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	bdpq_item_if.sink       item,
	bdpq_result_if.source   result,
	bdpq_cfg_if.sink        cfg
);

	// input register
	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	btn_vec_t            raw_s1;

	// block state
	hist_t               hist_q [NUM_BUTTONS];
	btn_vec_t            stable_q;
	btn_vec_t            prev_q;
	btn_vec_t            latch_q;
	logic [AGREE_W-1:0]  agree_q;

	// result register
	logic                res_valid_q;
	cmd_t                cmd_q;
	btn_vec_t            stable_out_q;
	btn_vec_t            latch_out_q;

	logic                advance;
	hist_t               win;
	hist_t               hist_n [NUM_BUTTONS];
	btn_vec_t            stable_n;
	btn_vec_t            prev_n;
	btn_vec_t            latch_n;
	btn_vec_t            eval_level;
	btn_vec_t            fetch_sel;
	cmd_t                fetch_cmd;
	cmd_t                cmd_n;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// window of newest samples; zero acts as one, large values saturate
	always_comb begin
		for (int i = 0; i < HISTORY_BITS; i++) begin
			win[i] = (i == 0) || (i < int'(agree_q));
		end
	end

	always_comb begin
		hist_t w;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			w = hist_q[b] & win;
			if (w == win) begin
				eval_level[b] = 1'b1;
			end else if (w == '0) begin
				eval_level[b] = 1'b0;
			end else begin
				eval_level[b] = stable_q[b];
			end
		end
	end

	// lowest pending press wins
	always_comb begin
		fetch_sel = '0;
		fetch_cmd = '0;
		for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
			if (latch_q[b]) begin
				fetch_sel    = '0;
				fetch_sel[b] = 1'b1;
				fetch_cmd    = CMD_W'(b + 1);
			end
		end
	end

	always_comb begin
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			hist_n[b] = hist_q[b];
		end
		stable_n = stable_q;
		prev_n   = prev_q;
		latch_n  = latch_q;
		cmd_n    = '0;
		unique case (action_t'(action_s1))
			ACT_SAMPLE: begin
				for (int b = 0; b < NUM_BUTTONS; b++) begin
					hist_n[b] = HISTORY_BITS'({hist_q[b], raw_s1[b]});
				end
			end
			ACT_EVALUATE: begin
				prev_n   = stable_q;
				stable_n = eval_level;
				latch_n  = latch_q | (stable_q & ~eval_level);
			end
			ACT_FETCH: begin
				latch_n = latch_q & ~fetch_sel;
				cmd_n   = fetch_cmd;
			end
			ACT_NONE: begin
				cmd_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			stable_q    <= '1;
			prev_q      <= '1;
			latch_q     <= '0;
			agree_q     <= AGREE_RESET;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				hist_q[b] <= '0;
			end
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				stable_q    <= stable_n;
				prev_q      <= prev_n;
				latch_q     <= latch_n;
				for (int b = 0; b < NUM_BUTTONS; b++) begin
					hist_q[b] <= hist_n[b];
				end
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				agree_q <= cfg.agree_count;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1 <= item.action;
			raw_s1    <= item.raw_buttons;
		end
		if (advance) begin
			cmd_q        <= cmd_n;
			stable_out_q <= stable_n;
			latch_out_q  <= latch_n;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.command         = cmd_q;
	assign result.stable_levels   = stable_out_q;
	assign result.pending_presses = latch_out_q;

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce and press queue testbench
// Drives sample, evaluate, fetch and unused requests through the valid/ready
// channels under random stalls on both sides and several agree counts. An
// in-bench model of the debouncer predicts each result, and every result is
// checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
	import bdpq_pkg::*;

	localparam int HOLD_CYCLES  = 40;
	localparam int PHASE_ITEMS  = 62;
	localparam int SETTLE_TICKS = 8;

	typedef struct packed {
		cmd_t     command;
		btn_vec_t levels;
		btn_vec_t presses;
	} press_result_t;

	// Debouncer model and the queue of results it still expects.
	class debounce_scoreboard;
		hist_t              history [NUM_BUTTONS];
		btn_vec_t           level;
		btn_vec_t           prev_level;
		btn_vec_t           presses;
		logic [AGREE_W-1:0] agree;
		press_result_t      expected_q [$];
		int unsigned        fail_count;

		function new();
			foreach (history[b]) history[b] = '0;
			level      = '1;
			prev_level = '1;
			presses    = '0;
			agree      = AGREE_RESET;
			fail_count = 0;
		endfunction

		function void set_agree(logic [AGREE_W-1:0] value);
			agree = value;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_request(action_t act, btn_vec_t raw);
			press_result_t res;
			int unsigned   n;
			hist_t         win;
			hist_t         w;
			bit            found;
			res.command = '0;
			case (act)
				ACT_SAMPLE: begin
					foreach (history[b]) history[b] = {history[b][HISTORY_BITS-2:0], raw[b]};
				end
				ACT_EVALUATE: begin
					// Zero agree acts as one; anything past the history length saturates.
					n = agree;
					if (n == 0) n = 1;
					if (n > HISTORY_BITS) n = HISTORY_BITS;
					win = hist_t'((1 << n) - 1);
					prev_level = level;
					for (int b = 0; b < NUM_BUTTONS; b++) begin
						w = history[b] & win;
						if (w == win) level[b] = 1'b1;
						else if (w == '0) level[b] = 1'b0;
					end
					presses |= prev_level & ~level;
				end
				ACT_FETCH: begin
					found = 1'b0;
					for (int b = 0; b < NUM_BUTTONS; b++) begin
						if (!found && presses[b]) begin
							found       = 1'b1;
							presses[b]  = 1'b0;
							res.command = cmd_t'(b + 1);
						end
					end
				end
				default: ;
			endcase
			res.levels  = level;
			res.presses = presses;
			expected_q.push_back(res);
		endfunction

		function void flag(string what);
			fail_count++;
			if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, what);
		endfunction

		function void check_result(cmd_t cmd, btn_vec_t lv, btn_vec_t pr);
			press_result_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected result cmd=%0d levels=%02h presses=%02h",
					cmd, lv, pr));
				return;
			end
			want = expected_q.pop_front();
			if (cmd !== want.command || lv !== want.levels || pr !== want.presses)
				flag($sformatf({"result mismatch: exp cmd=%0d levels=%02h presses=%02h, ",
					"got cmd=%0d levels=%02h presses=%02h"}, want.command, want.levels,
					want.presses, cmd, lv, pr));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bdpq_item_if   item_ch ();
	bdpq_result_if result_ch ();
	bdpq_cfg_if    cfg_ch ();

	debounce_scoreboard board = new();

	bit       src_idle_on;
	bit       sink_idle_on;
	bit       hold_req;
	btn_vec_t target_levels;

	button_debounce_press_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#(1_000_000);
		$display("Verification failed");
		$finish;
	end

	// Result side: random stalls per result, plus one long hold on request.
	initial begin : result_sink
		int unsigned wait_left;
		wait_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				board.check_result(result_ch.command, result_ch.stable_levels,
					result_ch.pending_presses);
				wait_left = sink_idle_on ? $urandom_range(0, 6) : 0;
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				wait_left = HOLD_CYCLES;
			end
			if (wait_left > 0) begin
				result_ch.ready <= 1'b0;
				wait_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input action_t act, input btn_vec_t raw);
		int unsigned gap;
		gap = src_idle_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.action      <= act;
		item_ch.raw_buttons <= raw;
		do @(posedge clk); while (!item_ch.ready);
		board.note_request(act, raw);
	endtask

	// Drop valid and hold until every outstanding result has come back.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic write_agree(input logic [AGREE_W-1:0] value);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.agree_count <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		board.set_agree(value);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned pick;
		btn_vec_t    raw;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// Mostly steady buttons that occasionally change, with bounce on top.
				if ($urandom_range(0, 5) == 0)
					target_levels[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
				raw = target_levels;
				if ($urandom_range(0, 5) == 0) raw ^= btn_vec_t'($urandom());
				send_request(ACT_SAMPLE, raw);
			end else if (pick < 78) begin
				send_request(ACT_EVALUATE, btn_vec_t'($urandom()));
			end else if (pick < 96) begin
				send_request(ACT_FETCH, btn_vec_t'($urandom()));
			end else begin
				send_request(ACT_NONE, btn_vec_t'($urandom()));
			end
		end
	endtask

	initial begin : stimulus
		logic [AGREE_W-1:0] agree_plan [6];
		agree_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd6};
		item_ch.valid       <= 1'b0;
		item_ch.action      <= ACT_NONE;
		item_ch.raw_buttons <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.agree_count  <= '0;
		src_idle_on   = 1'b0;
		sink_idle_on  = 1'b0;
		hold_req      = 1'b0;
		target_levels = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// History is all zeros after reset, so the first evaluate drops every level.
		send_request(ACT_EVALUATE, 6'h00);
		repeat (7) send_request(ACT_FETCH, 6'h3F);
		send_request(ACT_NONE, 6'h2A);
		repeat (4) send_request(ACT_SAMPLE, 6'h3F);
		send_request(ACT_EVALUATE, 6'h3F);
		send_request(ACT_SAMPLE, 6'h15);
		send_request(ACT_SAMPLE, 6'h2A);
		// Mixed windows leave the levels where they are.
		send_request(ACT_EVALUATE, 6'h00);
		repeat (4) send_request(ACT_SAMPLE, 6'h00);
		send_request(ACT_EVALUATE, 6'h00);
		repeat (2) send_request(ACT_FETCH, 6'h00);

		foreach (agree_plan[p]) begin
			drain_results();
			write_agree(agree_plan[p]);
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			if (p == 1) begin
				// Flood the input while the result side holds off.
				src_idle_on = 1'b0;
				hold_req    = 1'b1;
			end
			run_random(PHASE_ITEMS);
		end

		drain_results();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (board.fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
